[sv/spf_pkg.sv]
// Shared types and constants for the serial packet framer.
// Used by the front end, the command queue, the back end and the top level.
package spf_pkg;

  // Header start bytes
  localparam logic [7:0] HDR_START0 = 8'hAA;
  localparam logic [7:0] HDR_START1 = 8'h55;

  // Fletcher sums run modulo this value
  localparam logic [8:0] FLETCHER_MOD = 9'd255;
  localparam logic [7:0] CHECK_BASE  = 8'hFF;

  // Configuration register indexes
  localparam int unsigned CFG_AW = 2;
  localparam logic [CFG_AW-1:0] CFG_PACKET_TYPE   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_SIZE_BYTE     = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_FILLER_ENABLE = 2'd2;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // One classified input item with the header settings captured at acceptance
  typedef struct packed {
    logic       first;
    logic [7:0] ptype;
    logic [7:0] psize;
    logic       filler;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  // Back end status seen by the top level
  typedef struct packed {
    logic [7:0] fl_a;
    logic [7:0] fl_b;
  } back_stat_t;

endpackage

[sv/spf_front.sv]
// Front end of the framer: configuration registers, item acceptance and
// packet-start classification. Depends on spf_pkg.
module spf_front import spf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic [7:0] ptype_r;
  logic [7:0] psize_r;
  logic       filler_r;
  logic       in_packet_r;
  logic       in_packet_nxt;

  // Accept while the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Classify the item and capture the header settings
  always_comb begin
    q_cmd.first  = !in_packet_r;
    q_cmd.ptype  = ptype_r;
    q_cmd.psize  = psize_r;
    q_cmd.filler = filler_r;
    q_cmd.data   = in_data;
    q_cmd.last   = in_last;
  end

  // Track packet membership: a last item closes the packet
  always_comb begin
    in_packet_nxt = in_packet_r;
    if (q_push) begin
      in_packet_nxt = !in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptype_r     <= '0;
      psize_r     <= '0;
      filler_r    <= 1'b1;
      in_packet_r <= 1'b0;
    end else begin
      in_packet_r <= in_packet_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_PACKET_TYPE:   ptype_r  <= cfg_wdata;
          CFG_SIZE_BYTE:     psize_r  <= cfg_wdata;
          CFG_FILLER_ENABLE: filler_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

[sv/spf_queue.sv]
// Short command queue that decouples the front end from the back end.
// Depends on spf_pkg for the command type and depth.
module spf_queue import spf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] count_r;
  logic [QCW-1:0] count_nxt;
  logic           do_pop;

  assign full   = (count_r == QCW'(QDEPTH));
  assign empty  = (count_r == '0);
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

[sv/spf_back.sv]
// Back end of the framer: byte sequencer for header, filler, payload and
// check bytes, Fletcher sums and the output register. Depends on spf_pkg.
module spf_back import spf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data,
  output logic       out_last,
  output back_stat_t stat
);

  typedef enum logic [3:0] {
    PH_START, PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4,
    PH_FILL, PH_DATA, PH_C0, PH_C1
  } phase_t;

  phase_t     phase_r;
  phase_t     phase_nxt;
  phase_t     eff;
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_last_r;
  logic [7:0] a_r;
  logic [7:0] b_r;
  logic [7:0] a_nxt;
  logic [7:0] b_nxt;
  logic [7:0] a_base;
  logic [7:0] b_base;
  logic [7:0] byte_val;
  logic [7:0] hsum;
  logic [7:0] hchk;
  logic [8:0] a_sum;
  logic [8:0] b_sum;
  logic [7:0] a_fold;
  logic [7:0] b_fold;
  logic [8:0] ab_sum;
  logic [7:0] c0;
  logic [8:0] ac_sum;
  logic [7:0] c1;
  logic       adv;

  assign adv = head_valid && (!out_valid_r || out_ready);

  // A new command starts with the header when it opens a packet
  always_comb begin
    if (phase_r == PH_START) begin
      eff = head.first ? PH_HDR0 : PH_DATA;
    end else begin
      eff = phase_r;
    end
  end

  // Header check and trailer bytes
  always_comb begin
    hsum   = HDR_START0 + HDR_START1 + head.ptype + head.psize;
    hchk   = 8'(8'd0 - hsum);
    ab_sum = {1'b0, a_r} + {1'b0, b_r};
    c0     = CHECK_BASE - ((ab_sum >= FLETCHER_MOD) ? 8'(ab_sum - FLETCHER_MOD) : ab_sum[7:0]);
    ac_sum = {1'b0, a_r} + {1'b0, c0};
    c1     = CHECK_BASE - ((ac_sum >= FLETCHER_MOD) ? 8'(ac_sum - FLETCHER_MOD) : ac_sum[7:0]);
  end

  // Select the emitted byte and the following phase
  always_comb begin
    byte_val  = 8'h00;
    phase_nxt = phase_r;
    pop       = 1'b0;
    unique case (eff)
      PH_HDR0: begin
        byte_val  = HDR_START0;
        phase_nxt = PH_HDR1;
      end
      PH_HDR1: begin
        byte_val  = HDR_START1;
        phase_nxt = PH_HDR2;
      end
      PH_HDR2: begin
        byte_val  = head.ptype;
        phase_nxt = PH_HDR3;
      end
      PH_HDR3: begin
        byte_val  = head.psize;
        phase_nxt = PH_HDR4;
      end
      PH_HDR4: begin
        byte_val  = hchk;
        phase_nxt = head.filler ? PH_FILL : PH_DATA;
      end
      PH_FILL: begin
        byte_val  = 8'h00;
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        byte_val  = head.data;
        phase_nxt = head.last ? PH_C0 : PH_START;
        pop       = adv && !head.last;
      end
      PH_C0: begin
        byte_val  = c0;
        phase_nxt = PH_C1;
      end
      PH_C1: begin
        byte_val  = c1;
        phase_nxt = PH_START;
        pop       = adv;
      end
      default: begin
        byte_val  = 8'h00;
        phase_nxt = PH_START;
      end
    endcase
  end

  // Fold non-check bytes into Fletcher sums; headers restart, C1 clears them
  always_comb begin
    a_base = (eff == PH_HDR0) ? 8'h00 : a_r;
    b_base = (eff == PH_HDR0) ? 8'h00 : b_r;
    a_sum  = {1'b0, a_base} + {1'b0, byte_val};
    a_fold = (a_sum >= FLETCHER_MOD) ? 8'(a_sum - FLETCHER_MOD) : a_sum[7:0];
    b_sum  = {1'b0, b_base} + {1'b0, a_fold};
    b_fold = (b_sum >= FLETCHER_MOD) ? 8'(b_sum - FLETCHER_MOD) : b_sum[7:0];
    priority if (eff == PH_C1) begin
      a_nxt = 8'h00;
      b_nxt = 8'h00;
    end else if (eff == PH_C0) begin
      a_nxt = a_r;
      b_nxt = b_r;
    end else begin
      a_nxt = a_fold;
      b_nxt = b_fold;
    end
  end

  // Hold state, sums and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      out_valid_r <= 1'b0;
      a_r         <= '0;
      b_r         <= '0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      out_valid_r <= 1'b1;
      out_data_r  <= byte_val;
      out_last_r  <= (eff == PH_C1);
      a_r         <= a_nxt;
      b_r         <= b_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;
  assign stat.fl_a  = a_r;
  assign stat.fl_b  = b_r;

endmodule

[sv/serial_packet_framer_fletcher_top.sv]
// Serial packet framer with header check and Fletcher-16 trailer.
// With the queue empty and the output register free, an accepted item is written
// into the queue and its first byte is then loaded into the output register.
// The back end emits one byte per cycle while a command waits and the output is free;
// a start adds the header (and filler), a last byte the check; queue holds 4 items.
// Reset (rst_n low, synchronous) empties the queue and output, zeroes the sums,
// sets packet type and size to 0 and filler enable to 1.
module serial_packet_framer_fletcher_top import spf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] payload_byte
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] out_byte
  output logic              out_tlast
);

  cmd_t       push_cmd;
  cmd_t       head;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  back_stat_t stat;

  spf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  spf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .pop     (q_pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  spf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_valid(!q_empty),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .stat      (stat)
  );

  // Fletcher sums stay reduced below the modulus
  a_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.fl_a != 8'hFF) && (stat.fl_b != 8'hFF))
    else $error("fletcher sum out of range");

  // Queue is never full and empty at once
  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue count inconsistent");

  // Reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A pop only happens with a command present
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

[bench/spf_frame_checker.sv]
// Scoreboard for the serial packet framer: watches the register port and both streams,
// predicts every framed byte and compares it against what the block emits.
// Depends on spf_pkg for the header bytes, register indexes and the Fletcher modulus.
module spf_frame_checker import spf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [7:0]        out_tdata,
  input  logic              out_tlast,
  output int                fail_count,
  output int                pending,
  output int                bytes_checked,
  output int                packets_closed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       fin;
  } framed_t;

  // Mirrored registers and packet state
  logic [7:0] hdr_type;
  logic [7:0] hdr_size;
  logic       filler_on;
  logic       in_frame;
  logic [7:0] sum_a;
  logic [7:0] sum_b;
  framed_t    framed_q[$];

  // Add two values that are each below 2 * 255 in total, result kept in 0..254
  function automatic logic [7:0] mod255_add(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= FLETCHER_MOD) s = s - FLETCHER_MOD;
    return s[7:0];
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Queue one framed byte and fold it into the running sums
  task automatic emit_folded(input logic [7:0] v);
    sum_a = mod255_add(sum_a, v);
    sum_b = mod255_add(sum_b, sum_a);
    framed_q.push_back('{value: v, fin: 1'b0});
  endtask

  // Work out every byte one payload item produces
  task automatic frame_payload(input logic [7:0] data, input logic is_last);
    logic [7:0] hsum;
    logic [7:0] c0;
    logic [7:0] c1;
    if (!in_frame) begin
      hsum = HDR_START0 + HDR_START1 + hdr_type + hdr_size;
      sum_a = '0;
      sum_b = '0;
      emit_folded(HDR_START0);
      emit_folded(HDR_START1);
      emit_folded(hdr_type);
      emit_folded(hdr_size);
      emit_folded(8'h00 - hsum);
      if (filler_on) emit_folded(8'h00);
      in_frame = 1'b1;
    end
    emit_folded(data);
    // Trailer bytes are not folded; they zero the receiver's check
    if (is_last) begin
      c0 = CHECK_BASE - mod255_add(sum_a, sum_b);
      c1 = CHECK_BASE - mod255_add(sum_a, c0);
      framed_q.push_back('{value: c0, fin: 1'b0});
      framed_q.push_back('{value: c1, fin: 1'b1});
      in_frame = 1'b0;
      sum_a = '0;
      sum_b = '0;
    end
  endtask

  task automatic check_output(input logic [7:0] got_byte, input logic got_end);
    framed_t want;
    if (framed_q.size() == 0) begin
      report_mismatch($sformatf("byte %02h tlast %b with nothing expected", got_byte, got_end));
      return;
    end
    want = framed_q.pop_front();
    if (got_byte !== want.value)
      report_mismatch($sformatf("byte #%0d: got %02h, want %02h",
                                bytes_checked, got_byte, want.value));
    if (got_end !== want.fin)
      report_mismatch($sformatf("byte #%0d: tlast %b, want %b",
                                bytes_checked, got_end, want.fin));
    if (want.fin) packets_closed++;
    bytes_checked++;
  endtask

  // Sample everything at the rising edge; writes only come while the block is idle
  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_type  = '0;
      hdr_size  = '0;
      filler_on = 1'b1;
      in_frame  = 1'b0;
      sum_a     = '0;
      sum_b     = '0;
      framed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PACKET_TYPE:   hdr_type  = cfg_wdata;
          CFG_SIZE_BYTE:     hdr_size  = cfg_wdata;
          CFG_FILLER_ENABLE: filler_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) frame_payload(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_output(out_tdata, out_tlast);
    end
    pending = framed_q.size();
  end

endmodule

[bench/serial_packet_framer_fletcher_top_tb.sv]
// Top of the framer testbench: clock, reset, register writes, payload stimulus and verdict.
// Instantiates the framer and spf_frame_checker; uses spf_pkg for register indexes.
module serial_packet_framer_fletcher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 36;
  localparam logic [CFG_AW-1:0] CFG_UNUSED = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [7:0]        cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;   // [7:0] payload_byte
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;  // [7:0] out_byte
  logic              out_tlast;

  bit steady;
  int fail_count;
  int pending;
  int bytes_checked;
  int packets_closed;
  int reg_writes;
  int items_sent;

  serial_packet_framer_fletcher_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  spf_frame_checker frame_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .pending        (pending),
    .bytes_checked  (bytes_checked),
    .packets_closed (packets_closed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: stall at random unless in a steady stretch
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Abort if nothing moves on any port for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d bytes still due", quiet, pending);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Present one payload item, with random gaps ahead of it; returns at a falling edge
  task automatic send_item(input logic [7:0] b, input logic l);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Hold off the sender until every predicted byte is out, then pad for the pipeline
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    reg_writes++;
  endtask

  // Mostly random payload with some all-zero and all-one bytes
  task automatic send_random_packet(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      if ($urandom_range(0, 39) == 0) wait_drained();
      send_item(b, i == len - 1);
    end
  endtask

  initial begin
    logic [7:0] ptype;
    logic [7:0] psize;
    logic [7:0] pfill;
    int sent;
    int len;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    steady    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: one-byte packet, then a short packet of extremes
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);

    // Top settings, filler off via a value with upper bits set
    wait_drained();
    write_reg(CFG_PACKET_TYPE, 8'hFF);
    write_reg(CFG_SIZE_BYTE, 8'hFF);
    write_reg(CFG_FILLER_ENABLE, 8'hFE);
    send_item(8'hAA, 1'b1);
    send_item(8'h55, 1'b0);
    send_item(8'h01, 1'b1);

    // Header sum of zero gives a zero check byte; run of 0xFF wraps the sums
    wait_drained();
    write_reg(CFG_PACKET_TYPE, 8'h01);
    write_reg(CFG_SIZE_BYTE, 8'h00);
    write_reg(CFG_FILLER_ENABLE, 8'h03);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);

    // Write to an index past the register list must change nothing
    wait_drained();
    write_reg(CFG_UNUSED, 8'hFF);
    send_item(8'h7F, 1'b1);

    // Register change inside a packet only affects the next header
    send_item(8'h12, 1'b0);
    send_item(8'h34, 1'b0);
    wait_drained();
    write_reg(CFG_PACKET_TYPE, 8'h5A);
    send_item(8'h56, 1'b1);
    send_item(8'h78, 1'b1);

    // Random packets across several settings; one phase without any idling
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          ptype = 8'h00;
          psize = 8'h00;
          pfill = 8'h01;
        end
        1: begin
          ptype = 8'hFF;
          psize = 8'hFF;
          pfill = 8'h00;
        end
        default: begin
          ptype = 8'($urandom);
          psize = 8'($urandom);
          pfill = 8'($urandom);
        end
      endcase
      write_reg(CFG_PACKET_TYPE, ptype);
      write_reg(CFG_SIZE_BYTE, psize);
      write_reg(CFG_FILLER_ENABLE, pfill);
      steady = (ph == 3);
      sent = 0;
      while (sent < 21) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 5);
        send_random_packet(len);
        sent += len;
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (4) @(negedge clk);
    $display("run: %0d payload items framed into %0d packets, %0d output bytes compared",
             items_sent, packets_closed, bytes_checked);
    $display("run: %0d register writes, header settings from all-zero to all-one, filler on/off",
             reg_writes);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
